@@ design/lcbp_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types for the light command byte parser.
// No dependencies; imported by every module of the block.
package lcbp_pkg;

	localparam int BYTE_W          = 8;
	localparam int LIGHT_ID_W      = 5;
	localparam int LIGHT_STATE_W   = 3;
	localparam int DELAY_W         = 32;
	localparam int DELAY_BYTES_DEF = 4;

	localparam logic [BYTE_W-1:0] MARKER_BYTE = 8'hFE;
	localparam logic [BYTE_W-1:0] MODE_LIMIT  = 8'd3;

	localparam logic RESULT_LIGHT = 1'b0;
	localparam logic RESULT_PULSE = 1'b1;

	// Per-byte decision from the decoder to the frame buffer and result stage.
	typedef struct packed {
		logic emit_light;
		logic emit_pulse;
		logic wr_en;
	} lcbp_ctl_t;

endpackage

@@ design/lcbp_decode.sv @@
`timescale 1ns / 1ps
// Mode, marker and frame-count state of the light command byte parser.
// Depends on lcbp_pkg.
module lcbp_decode
	import lcbp_pkg::*;
#(
	parameter int DELAY_BYTES = DELAY_BYTES_DEF,
	parameter int FRAME_LEN   = 1 + 2 * DELAY_BYTES,
	parameter int IDX_W       = $clog2(FRAME_LEN)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] byte_in,
	output lcbp_ctl_t         ctl,
	output logic [IDX_W-1:0]  wr_idx
);

	localparam int CNT_W = $clog2(FRAME_LEN + 1);
	localparam logic [CNT_W-1:0] FRAME_LEN_C = CNT_W'(FRAME_LEN);

	typedef enum logic [1:0] {
		MODE_OFF   = 2'd0,
		MODE_LIGHT = 2'd1,
		MODE_PULSE = 2'd2
	} mode_t;

	mode_t             mode_q, mode_d;
	logic              marker_q, marker_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  count_inc;

	assign wr_idx    = count_q[IDX_W-1:0];
	assign count_inc = count_q + CNT_W'(1);

	always_comb begin
		mode_d   = mode_q;
		marker_d = marker_q;
		count_d  = count_q;
		ctl      = '0;
		if (marker_q && byte_in < MODE_LIMIT) begin
			// valid selector: switch mode and restart the frame
			marker_d = 1'b0;
			mode_d   = mode_t'(byte_in[1:0]);
			count_d  = '0;
		end else if (!marker_q && byte_in == MARKER_BYTE && mode_q != MODE_PULSE) begin
			marker_d = 1'b1;
		end else begin
			marker_d = 1'b0;
			case (mode_q)
				MODE_LIGHT: begin
					ctl.emit_light = step;
				end
				MODE_PULSE: begin
					if (count_q < FRAME_LEN_C) begin
						ctl.wr_en = step;
						count_d   = count_inc;
					end
					if (count_d >= FRAME_LEN_C) begin
						ctl.emit_pulse = step;
						mode_d         = MODE_OFF;
						count_d        = '0;
					end
				end
				default: begin
					// off: drop the byte
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_OFF;
			marker_q <= 1'b0;
			count_q  <= '0;
		end else if (step) begin
			mode_q   <= mode_d;
			marker_q <= marker_d;
			count_q  <= count_d;
		end
	end

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.emit_light, ctl.emit_pulse}))
		else $error("light and pulse result in the same byte");

	a_pulse_to_off: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit_pulse |=> mode_q == MODE_OFF && count_q == '0)
		else $error("block did not return to off after a pulse frame");

	a_no_marker_in_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		marker_q |-> mode_q != MODE_PULSE)
		else $error("marker armed while in pulse mode");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < FRAME_LEN_C)
		else $error("frame count ran past the frame length");

endmodule

@@ design/lcbp_frame.sv @@
`timescale 1ns / 1ps
// Pulse frame buffer and little-endian delay assembly.
// Depends on lcbp_pkg.
module lcbp_frame
	import lcbp_pkg::*;
#(
	parameter int DELAY_BYTES = DELAY_BYTES_DEF,
	parameter int FRAME_LEN   = 1 + 2 * DELAY_BYTES,
	parameter int IDX_W       = $clog2(FRAME_LEN)
) (
	input  logic                      clk,
	input  lcbp_ctl_t                 ctl,
	input  logic [IDX_W-1:0]          wr_idx,
	input  logic [BYTE_W-1:0]         byte_in,
	output logic [BYTE_W-1:0]         pulse_id,
	output logic signed [DELAY_W-1:0] on_delay,
	output logic signed [DELAY_W-1:0] off_delay
);

	// bytes beyond the fourth fall outside 32 bits
	localparam int NB = (DELAY_BYTES < 4) ? DELAY_BYTES : 4;

	logic [BYTE_W-1:0] bytes_q [FRAME_LEN];
	logic [BYTE_W-1:0] view    [FRAME_LEN];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			bytes_q[wr_idx] <= byte_in;
		end
	end

	// the closing byte is still in flight: bypass it into the view
	always_comb begin
		for (int i = 0; i < FRAME_LEN; i++) begin
			view[i] = (ctl.wr_en && wr_idx == IDX_W'(i)) ? byte_in : bytes_q[i];
		end
	end

	assign pulse_id = view[0];

	always_comb begin
		logic [DELAY_W-1:0] raw_on;
		logic [DELAY_W-1:0] raw_off;
		raw_on  = '0;
		raw_off = '0;
		for (int i = 0; i < NB; i++) begin
			raw_on[8*i +: 8]  = view[1 + i];
			raw_off[8*i +: 8] = view[1 + DELAY_BYTES + i];
		end
		// sign-extend short delays
		for (int j = 0; j < DELAY_W; j++) begin
			if (j >= 8 * NB) begin
				raw_on[j]  = raw_on[8*NB-1];
				raw_off[j] = raw_off[8*NB-1];
			end
		end
		on_delay  = raw_on;
		off_delay = raw_off;
	end

endmodule

@@ design/light_command_byte_parser.sv @@
`timescale 1ns / 1ps
// Light command byte parser: decodes a serial command byte stream into light
// updates and pulse configurations. Depends on lcbp_pkg, lcbp_decode, lcbp_frame.
// Results: a byte passes the input register, then the result register; out_stall holds a result.
// Throughput: one byte per cycle unless out_stall holds a result; the input register
// and the result register sit on either side of a single level of decode logic.
// Reset: arst_n clears mode to off, the marker and the frame count at once.
module light_command_byte_parser
	import lcbp_pkg::*;
#(
	parameter int DELAY_BYTES = DELAY_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// request in
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [BYTE_W-1:0]                rx_byte,
	// result out
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             result_kind,
	output logic [LIGHT_ID_W-1:0]            light_id,
	output logic [LIGHT_STATE_W-1:0]         light_state,
	output logic [BYTE_W-1:0]                pulse_id,
	output logic signed [DELAY_W-1:0]        on_delay,
	output logic signed [DELAY_W-1:0]        off_delay
);

	localparam int FRAME_LEN = 1 + 2 * DELAY_BYTES;
	localparam int IDX_W     = $clog2(FRAME_LEN);

	// input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] rx_s1;

	// result stage
	logic                      valid_s2;
	logic                      kind_s2;
	logic [LIGHT_ID_W-1:0]     light_id_s2;
	logic [LIGHT_STATE_W-1:0]  light_state_s2;
	logic [BYTE_W-1:0]         pulse_id_s2;
	logic [DELAY_W-1:0]        on_delay_s2;
	logic [DELAY_W-1:0]        off_delay_s2;

	logic                      advance;
	logic                      step;
	lcbp_ctl_t                 ctl;
	logic [IDX_W-1:0]          wr_idx;
	logic [BYTE_W-1:0]         frame_pulse_id;
	logic signed [DELAY_W-1:0] frame_on_delay;
	logic signed [DELAY_W-1:0] frame_off_delay;

	// The result register moves when it is empty or being taken; the input
	// register is consumed whenever the result register moves.
	assign advance  = !valid_s2 || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// hold the byte while stalled
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rx_s1 <= rx_byte;
		end
	end

	lcbp_decode #(
		.DELAY_BYTES (DELAY_BYTES),
		.FRAME_LEN   (FRAME_LEN),
		.IDX_W       (IDX_W)
	) u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (rx_s1),
		.ctl     (ctl),
		.wr_idx  (wr_idx)
	);

	lcbp_frame #(
		.DELAY_BYTES (DELAY_BYTES),
		.FRAME_LEN   (FRAME_LEN),
		.IDX_W       (IDX_W)
	) u_frame (
		.clk       (clk),
		.ctl       (ctl),
		.wr_idx    (wr_idx),
		.byte_in   (rx_s1),
		.pulse_id  (frame_pulse_id),
		.on_delay  (frame_on_delay),
		.off_delay (frame_off_delay)
	);

	// Advance the result register; a byte without a result leaves it empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= ctl.emit_light || ctl.emit_pulse;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (ctl.emit_light || ctl.emit_pulse)) begin
			if (ctl.emit_pulse) begin
				kind_s2        <= RESULT_PULSE;
				light_id_s2    <= '0;
				light_state_s2 <= '0;
				pulse_id_s2    <= frame_pulse_id;
				on_delay_s2    <= frame_on_delay;
				off_delay_s2   <= frame_off_delay;
			end else begin
				kind_s2        <= RESULT_LIGHT;
				light_id_s2    <= rx_s1[BYTE_W-1 -: LIGHT_ID_W];
				light_state_s2 <= rx_s1[LIGHT_STATE_W-1:0];
				pulse_id_s2    <= '0;
				on_delay_s2    <= '0;
				off_delay_s2   <= '0;
			end
		end
	end

	assign out_valid   = valid_s2;
	assign result_kind = kind_s2;
	assign light_id    = light_id_s2;
	assign light_state = light_state_s2;
	assign pulse_id    = pulse_id_s2;
	assign on_delay    = on_delay_s2;
	assign off_delay   = off_delay_s2;

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(rx_s1))
		else $error("input stage lost a request while the result stage was full");

	a_result_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit_light || ctl.emit_pulse) |-> step)
		else $error("result produced without a byte being consumed");

	a_pulse_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == RESULT_PULSE |-> light_id == '0 && light_state == '0)
		else $error("pulse result carries light fields");

	a_light_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == RESULT_LIGHT
			|-> pulse_id == '0 && on_delay == '0 && off_delay == '0)
		else $error("light result carries pulse fields");

endmodule
